>>> hw/rtl/kscan_pkg.sv
// Shared types, constants and the unlock sequence table for the key scan report builder.
`default_nettype none

package kscan_pkg;

    localparam int NUM_KEYS        = 128;
    localparam int MAX_REPORT_KEYS = 6;
    localparam int KEY_W           = 7;
    localparam int CODE_W          = 8;
    localparam int SLOTS           = 6;
    localparam int COUNT_W         = 3;
    localparam int POS_W           = 3;
    localparam int SEQ_LEN         = 4;
    localparam int PRESS_BIT       = 7;

    // The keymap never holds more entries than a key index can address.
    localparam int KEYMAP_DEPTH = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
    localparam int KEYMAP_AW    = $clog2(KEYMAP_DEPTH);
    localparam int ENTRY_W      = CODE_W + 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;

    typedef enum logic
    {
        KIND_MAP_WRITE = 1'b0,
        KIND_SAMPLE    = 1'b1
    } kscan_kind_t;

    typedef struct packed
    {
        kscan_kind_t      kind;
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             last;
    } kscan_item_t;

    typedef struct packed
    {
        logic [CODE_W-1:0]            modifier_bits;
        logic [SLOTS-1:0][CODE_W-1:0] slot_code;
        logic [COUNT_W-1:0]           slot_count;
        logic                         overflow_flag;
        logic                         unlock_request;
    } kscan_report_t;

    function automatic logic [KEY_W-1:0] unlock_key(input logic [1:0] pos);
        logic [KEY_W-1:0] k;
        case (pos)
            2'd0:    k = 7'd1;
            2'd1:    k = 7'd16;
            2'd2:    k = 7'd6;
            2'd3:    k = 7'd11;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kscan_keymap_ram.sv
// Keymap memory: one write port and one registered read port.
`default_nettype none

module kscan_keymap_ram
    import kscan_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [KEYMAP_AW-1:0] wr_addr,
    input  wire logic [ENTRY_W-1:0]   wr_data,
    input  wire logic                 rd_en,
    input  wire logic [KEYMAP_AW-1:0] rd_addr,
    output logic      [ENTRY_W-1:0]   rd_data
);

    logic [ENTRY_W-1:0] mem [KEYMAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/kscan_scan_update.sv
// Per-scan accumulation of report slots, modifiers, overflow and the unlock tracker.
`default_nettype none

module kscan_scan_update
    import kscan_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire kscan_item_t        item,
    input  wire logic [ENTRY_W-1:0] entry,
    output logic                    report_fire,
    output kscan_report_t           report
);

    logic [SLOTS-1:0][CODE_W-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0]           used_reg, used_next;
    logic [CODE_W-1:0]            mod_reg, mod_next;
    logic                         halted_reg, halted_next;
    logic [1:0]                   seen_reg, seen_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         armed_reg, armed_next;
    logic                         hit_reg, hit_next;

    logic             is_sample;
    logic             take;
    logic             hit_adv;
    logic             hit_rep;
    logic [POS_W-1:0] pos_prev;

    assign is_sample = en && (item.kind == KIND_SAMPLE);
    assign take      = is_sample && !halted_reg && item.pressed;
    assign pos_prev  = pos_reg - POS_W'(1);

    assign hit_adv = !hit_reg && armed_reg && (pos_reg < POS_W'(SEQ_LEN))
                   && (item.key == unlock_key(pos_reg[1:0]));
    assign hit_rep = (pos_reg != '0) && (pos_reg <= POS_W'(SEQ_LEN))
                   && (item.key == unlock_key(pos_prev[1:0]));

    assign report_fire = is_sample && item.last;

    always_comb
    begin
        slot_next   = slot_reg;
        used_next   = used_reg;
        mod_next    = mod_reg;
        halted_next = halted_reg;
        seen_next   = seen_reg;
        pos_next    = pos_reg;
        armed_next  = armed_reg;
        hit_next    = hit_reg;
        report      = '0;

        if (take)
        begin
            if (seen_reg != 2'd2)
            begin
                seen_next = seen_reg + 2'd1;
            end
            if (hit_adv)
            begin
                hit_next   = 1'b1;
                armed_next = 1'b0;
                pos_next   = pos_reg + POS_W'(1);
            end
            else if (hit_rep)
            begin
                hit_next = 1'b1;
            end

            if (entry[CODE_W])
            begin
                mod_next = mod_reg | entry[CODE_W-1:0];
            end
            else if (used_reg >= COUNT_W'(MAX_REPORT_KEYS))
            begin
                halted_next = 1'b1;
            end
            else if (entry[CODE_W-1:0] != '0)
            begin
                slot_next[used_reg] = entry[CODE_W-1:0];
                used_next           = used_reg + COUNT_W'(1);
            end
        end

        if (report_fire)
        begin
            // An empty scan re-arms and keeps progress; otherwise only a scan with one key that hit keeps it.
            if (seen_next == 2'd0)
            begin
                armed_next = 1'b1;
            end
            else if (!((seen_next == 2'd1) && hit_next))
            begin
                pos_next = '0;
            end

            report.modifier_bits  = mod_next;
            report.slot_code      = slot_next;
            report.slot_count     = used_next;
            report.overflow_flag  = halted_next;
            report.unlock_request = (pos_next >= POS_W'(SEQ_LEN));

            if (pos_next >= POS_W'(SEQ_LEN))
            begin
                pos_next = '0;
            end

            slot_next   = '0;
            used_next   = '0;
            mod_next    = '0;
            halted_next = 1'b0;
            seen_next   = '0;
            hit_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            used_reg   <= '0;
            mod_reg    <= '0;
            halted_reg <= 1'b0;
            seen_reg   <= '0;
            pos_reg    <= '0;
            armed_reg  <= 1'b1;
            hit_reg    <= 1'b0;
        end
        else
        begin
            slot_reg   <= slot_next;
            used_reg   <= used_next;
            mod_reg    <= mod_next;
            halted_reg <= halted_next;
            seen_reg   <= seen_next;
            pos_reg    <= pos_next;
            armed_reg  <= armed_next;
            hit_reg    <= hit_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/key_scan_report_builder.sv
// Pipeline: an accepted beat is captured in the s1 registers alongside its registered keymap
// read; s1 then updates the scan state and, on a last sample beat, the report register behind m_tvalid.
// Throughput: one beat per cycle, set by a single keymap read or write per beat; the only
// stall is a new report while the previous one still waits in the output register.
// Reset: asynchronous, clears per-scan state and the unlock tracker; the keymap is not
// cleared and is undefined until written.
`default_nettype none

module key_scan_report_builder
    import kscan_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // key_index[6:0], sample_byte[14:7], entry_code[22:15], entry_is_modifier[23]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  wire logic                  s_tuser,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // modifier_bits[7:0], slot_code_0[15:8] .. slot_code_5[55:48], slot_count[58:56],
    // overflow_flag[59], unlock_request[60], zero[63:61]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic              accept;
    logic              s1_stall;
    logic              s1_fire;
    logic              in_range;
    kscan_kind_t       in_kind;
    logic [KEY_W-1:0]  in_key;
    logic              s1_valid_reg, s1_valid_next;
    kscan_item_t       s1_item_reg;
    logic              out_valid_reg, out_valid_next;
    kscan_report_t     out_report_reg;
    logic [ENTRY_W-1:0] rd_entry;
    logic              report_fire;
    kscan_report_t     report;

    assign in_kind  = kscan_kind_t'(s_tuser);
    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_range = ({1'b0, in_key} < (KEY_W+1)'(NUM_KEYS));

    // A report-producing beat waits while the output register is full and not taken.
    assign s1_stall = s1_valid_reg && s1_item_reg.last && (s1_item_reg.kind == KIND_SAMPLE)
                    && out_valid_reg && !m_tready;
    assign s_tready = !s1_stall;
    assign accept   = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && !s1_stall;

    kscan_keymap_ram u_keymap
    (
        .clk     (clk),
        .wr_en   (accept && (in_kind == KIND_MAP_WRITE) && in_range),
        .wr_addr (in_key[KEYMAP_AW-1:0]),
        .wr_data ({s_tdata[23], s_tdata[22:15]}),
        .rd_en   (accept && (in_kind == KIND_SAMPLE)),
        .rd_addr (in_key[KEYMAP_AW-1:0]),
        .rd_data (rd_entry)
    );

    kscan_scan_update u_update
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (s1_fire),
        .item        (s1_item_reg),
        .entry       (rd_entry),
        .report_fire (report_fire),
        .report      (report)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_stall)
        begin
            s1_valid_next = s1_valid_reg;
        end
        else
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (report_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.kind    <= in_kind;
            s1_item_reg.key     <= in_key;
            s1_item_reg.pressed <= s_tdata[KEY_W + PRESS_BIT] && in_range;
            s1_item_reg.last    <= s_tlast;
        end
        if (report_fire)
        begin
            out_report_reg <= report;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_report_reg.unlock_request,
                       out_report_reg.overflow_flag,
                       out_report_reg.slot_count,
                       out_report_reg.slot_code[5],
                       out_report_reg.slot_code[4],
                       out_report_reg.slot_code[3],
                       out_report_reg.slot_code[2],
                       out_report_reg.slot_code[1],
                       out_report_reg.slot_code[0],
                       out_report_reg.modifier_bits};

endmodule

`default_nettype wire
